[sv/lowmc_pkg.sv]
// ----------------------------------------------------------------------------
// LowMC package
// Shared types and constants for the LowMC encryption engine.
// ----------------------------------------------------------------------------
package lowmc_pkg;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  round_index;
        logic [5:0]  row_index;
        logic [63:0] data;
        logic [63:0] key;
    } lowmc_in_t;

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  round_number;
        logic        is_ciphertext;
        logic        last;
    } lowmc_out_t;

    localparam logic [2:0] OP_LOAD_LIN = 3'd0;
    localparam logic [2:0] OP_LOAD_KEY = 3'd1;
    localparam logic [2:0] OP_LOAD_RC  = 3'd2;
    localparam logic [2:0] OP_ENC      = 3'd3;
    localparam logic [2:0] OP_ENC_REC  = 3'd4;

    localparam logic [0:0] CFG_SBOX   = 1'b0;
    localparam logic [0:0] CFG_ROUNDS = 1'b1;

    // The 3-bit S-box.
    function automatic logic [2:0] lowmc_sbox(input logic [2:0] x);
        logic [2:0] y;
        unique case (x)
            3'd0: y = 3'd0;
            3'd1: y = 3'd1;
            3'd2: y = 3'd3;
            3'd3: y = 3'd6;
            3'd4: y = 3'd7;
            3'd5: y = 3'd4;
            3'd6: y = 3'd5;
            default: y = 3'd2;
        endcase
        return y;
    endfunction

endpackage

[sv/lowmc_ram.sv]
// ----------------------------------------------------------------------------
// LowMC generic RAM
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lowmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/lowmc_block_encrypt.sv]
// ----------------------------------------------------------------------------
// LowMC block encryption engine
// Encrypts one block per item using row tables held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  s_      | in        | op, round_index, row_index, data, key
//  m_      | out       | value, round_number, is_ciphertext, last
//  cfg_    | in        | register index, write data
//
// A load beat is written at the accepting edge.
// An encrypt runs R+1 passes, R being the rounds used, and output stalls can
// hold it: each pass reads one linear row and one key row per cycle, and the
// S-box layer is applied between passes.
// Reset is synchronous, active low, and clears control state and work_block_reg.
// A result beat waits in the output register; the S-box and output steps stall until taken.
// ----------------------------------------------------------------------------
module lowmc_block_encrypt
    import lowmc_pkg::*;
#(
    parameter int BLOCK_BITS = 64,
    parameter int ROUNDS     = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lowmc_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output lowmc_out_t m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int RB   = $clog2(BLOCK_BITS);
    localparam int RDB  = $clog2(ROUNDS + 1);
    localparam int LDEP = ROUNDS * BLOCK_BITS;
    localparam int KDEP = (ROUNDS + 1) * BLOCK_BITS;
    localparam int LAW  = $clog2(LDEP);
    localparam int KAW  = $clog2(KDEP);
    localparam int CAW  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int MAXG = BLOCK_BITS / 3;
    localparam logic [RB-1:0] LAST_ROW = RB'(BLOCK_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_SBOX = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [4:0]            sbox_reg, rounds_reg;
    logic [4:0]            groups, rounds_used;
    logic [BLOCK_BITS-1:0] s_reg, acc_reg, key_reg;
    logic [BLOCK_BITS-1:0] kacc_reg, work_block_reg;
    logic [RB-1:0]         row_reg;
    logic                  rd_valid_reg;
    logic [RB-1:0]         rd_row_reg;
    logic [RDB-1:0]        rnd_reg;
    logic                  rec_reg;
    logic                  mv_reg;
    lowmc_out_t            mout_reg;

    // Saturated configuration.
    assign groups      = (sbox_reg > 5'(MAXG)) ? 5'(MAXG) : sbox_reg;
    assign rounds_used = (rounds_reg > 5'(ROUNDS)) ? 5'(ROUNDS) : rounds_reg;

    assign s_ready   = (state_reg == ST_IDLE) && !mv_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid   = mv_reg;
    assign m_data    = mout_reg;

    logic accept;
    assign accept = s_valid && s_ready;

    // Table writes from load beats.
    logic                  lin_we, key_we, rc_we;
    logic [LAW-1:0]        lin_wa, lin_ra;
    logic [KAW-1:0]        key_wa, key_ra;
    logic [CAW-1:0]        rc_wa, rc_ra;
    logic [BLOCK_BITS-1:0] wdata, lin_rd, key_rd, rc_rd;

    assign wdata  = s_data.data[BLOCK_BITS-1:0];
    assign lin_we = accept && s_data.op == OP_LOAD_LIN
                    && 32'(s_data.round_index) < ROUNDS
                    && 32'(s_data.row_index) < BLOCK_BITS;
    assign key_we = accept && s_data.op == OP_LOAD_KEY
                    && 32'(s_data.round_index) <= ROUNDS
                    && 32'(s_data.row_index) < BLOCK_BITS;
    assign rc_we  = accept && s_data.op == OP_LOAD_RC
                    && 32'(s_data.round_index) < ROUNDS;
    assign lin_wa = LAW'(32'(s_data.round_index) * BLOCK_BITS + 32'(s_data.row_index));
    assign key_wa = KAW'(32'(s_data.round_index) * BLOCK_BITS + 32'(s_data.row_index));
    assign rc_wa  = CAW'(s_data.round_index);

    // Row reads: round rnd_reg uses linear round rnd-1 and key round rnd.
    assign lin_ra = LAW'((32'(rnd_reg) - 1) * BLOCK_BITS + 32'(row_reg));
    assign key_ra = KAW'(32'(rnd_reg) * BLOCK_BITS + 32'(row_reg));
    assign rc_ra  = CAW'(32'(rnd_reg) - 1);

    lowmc_ram #(.WIDTH(BLOCK_BITS), .DEPTH(LDEP)) u_lin (
        .aclk(aclk), .we(lin_we), .waddr(lin_wa), .wdata(wdata),
        .raddr(lin_ra), .rdata(lin_rd));
    lowmc_ram #(.WIDTH(BLOCK_BITS), .DEPTH(KDEP)) u_key (
        .aclk(aclk), .we(key_we), .waddr(key_wa), .wdata(wdata),
        .raddr(key_ra), .rdata(key_rd));
    lowmc_ram #(.WIDTH(BLOCK_BITS), .DEPTH(ROUNDS)) u_rc (
        .aclk(aclk), .we(rc_we), .waddr(rc_wa), .wdata(wdata),
        .raddr(rc_ra), .rdata(rc_rd));

    // S-box layer over the low groups.
    logic [BLOCK_BITS-1:0] sboxed;
    always_comb begin
        sboxed = s_reg;
        for (int g = 0; g < MAXG; g++) begin
            if (5'(g) < groups) begin
                sboxed[3*g +: 3] = lowmc_sbox(s_reg[3*g +: 3]);
            end
        end
    end

    logic issue;
    assign issue = (state_reg == ST_MUL);

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sbox_reg       <= 5'd10;
            rounds_reg     <= 5'd16;
            mv_reg         <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rnd_reg        <= '0;
            work_block_reg <= '0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            rd_row_reg   <= row_reg;
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SBOX:   sbox_reg   <= cfg_data;
                    CFG_ROUNDS: rounds_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (accept && (s_data.op == OP_ENC || s_data.op == OP_ENC_REC)) begin
                s_reg    <= s_data.data[BLOCK_BITS-1:0];
                key_reg  <= s_data.key[BLOCK_BITS-1:0];
                rec_reg  <= s_data.op == OP_ENC_REC;
                rnd_reg  <= '0;
                row_reg  <= '0;
                acc_reg  <= '0;
                kacc_reg <= '0;
            end
            if (issue && row_reg != LAST_ROW) begin
                row_reg <= row_reg + 1'b1;
            end
            // Accumulate one product bit per returned row.
            if (rd_valid_reg) begin
                acc_reg[rd_row_reg]  <= (rnd_reg == '0) ? 1'b0 : ^(lin_rd & s_reg);
                kacc_reg[rd_row_reg] <= ^(key_rd & key_reg);
            end
            // Close the pass once the last row has been folded in.
            if (state_reg == ST_FIN && !rd_valid_reg) begin
                row_reg <= '0;
                if (rnd_reg == '0) begin
                    s_reg <= s_reg ^ kacc_reg;
                end else begin
                    s_reg <= acc_reg ^ rc_rd ^ kacc_reg;
                end
                if (32'(rnd_reg) != 32'(rounds_used)) begin
                    rnd_reg <= rnd_reg + 1'b1;
                end
            end
            if (state_reg == ST_SBOX && !mv_reg) begin
                s_reg <= sboxed;
                if (rec_reg) begin
                    mv_reg <= 1'b1;
                    mout_reg <= '{value: 64'(sboxed), round_number: 5'(rnd_reg),
                                  is_ciphertext: 1'b0, last: 1'b0};
                end
            end
            if (state_reg == ST_OUT && !mv_reg) begin
                work_block_reg <= s_reg;
                mv_reg <= 1'b1;
                mout_reg <= '{value: 64'(s_reg), round_number: rounds_used,
                              is_ciphertext: 1'b1, last: 1'b1};
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.op == OP_ENC || s_data.op == OP_ENC_REC)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (row_reg == LAST_ROW) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (rd_valid_reg) begin
                    state_next = ST_FIN;
                end else if (32'(rnd_reg) == 32'(rounds_used)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SBOX;
                end
            end
            ST_SBOX: begin
                if (!mv_reg) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SBOX;
                end
            end
            ST_OUT: begin
                state_next = mv_reg ? ST_OUT : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // Inputs are refused while an item is in progress.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input accepted while busy");
    // A result beat is not overwritten before it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped");
    // The round counter never passes the round limit.
    a_rnd: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(rnd_reg) <= ROUNDS)
        else $error("round counter overflow");
`endif

endmodule
